// ----- hw/rtl/assert_macros.svh -----
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/jfna_pkg.sv -----
// constants and types of the four-neighbour average block
package jfna_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int SAMPLE_BITS   = 32;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
  localparam int CFG_W_BITS    = 11;
  localparam int CFG_H_BITS    = 13;
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_IDX_BITS  = 1;

  localparam int OQ_DEPTH    = 4;
  localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

  localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = SAMPLE_BITS + ROW_BITS + COL_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                    last;
    logic [COL_BITS-1:0]     column;
    logic [ROW_BITS-1:0]     row;
    logic [SAMPLE_BITS-1:0]  value;
  } result_t;

endpackage

// ----- hw/rtl/jfna_out_fifo.sv -----
// small result queue taking up to two beats a cycle and giving one when out_ready is high
module jfna_out_fifo
  import jfna_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             push_cnt,
  input  result_t                push_first,
  input  result_t                push_second,
  output logic [OQ_CNT_BITS-1:0] fill,
  output logic                   out_valid,
  input  logic                   out_ready,
  output result_t                out_item
);

  result_t                store_r [OQ_DEPTH];
  logic [OQ_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                   pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_item  = store_r[rd_ptr_r];
  assign fill      = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OQ_PTR_BITS'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + OQ_PTR_BITS'(pop);
    cnt_nxt    = cnt_r + OQ_CNT_BITS'(push_cnt) - OQ_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      store_r[wr_ptr_r] <= push_first;
    end
    if (push_cnt == 2'd2) begin
      store_r[wr_ptr_r + OQ_PTR_BITS'(1)] <= push_second;
    end
  end

endmodule

// ----- hw/rtl/jacobi_four_neighbour_average_top.sv -----
// top level of the streaming five-point jacobi relaxation sweep
//
// Samples (signed Q16.16) enter in row-major order, one per in_ beat. Each
// beat at row r >= 1 releases the relaxed value of point (r-1, c): an interior
// point becomes the floor of the sum of its four neighbours over four, points
// on the first or last row or column pass unchanged. Beats of the last row
// also release their own point, so on a grid of more than one row such a
// beat gives two out_ beats, the trailing point first; tlast marks the final
// beat caused by an input. The two most recent rows live in two synchronous
// row memories (1024 x 32 each) with a registered read. Inputs are not taken
// back to back: a beat writes both row memories at the current column, and
// in_tready stays low until the registered read for the next column has
// returned. A four-beat result queue lets the input side keep going while
// results wait; the input is held off when fewer than two queue places are
// free. Grid width and height saturate to 1..1024 and 1..4096. The row
// memories are not cleared, so no clearing pass runs after reset. Configure
// only while no grid is in flight.

`include "assert_macros.svh"

module jacobi_four_neighbour_average_top
  import jfna_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // [31:0] sample
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,  // [31:0] value, [43:32] row, [53:44] column
  output logic                      out_tlast   // last_of_run
);

  // configuration registers
  logic [CFG_W_BITS-1:0] grid_width_r;
  logic [CFG_H_BITS-1:0] grid_height_r;
  logic [CFG_W_BITS-1:0] eff_w;
  logic [CFG_H_BITS-1:0] eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= CFG_W_BITS'(64);
      grid_height_r <= CFG_H_BITS'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[CFG_W_BITS-1:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_wdata[CFG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, oversize saturates
  always_comb begin
    if (grid_width_r == '0) begin
      eff_w = CFG_W_BITS'(1);
    end else if (grid_width_r > CFG_W_BITS'(MAX_WIDTH)) begin
      eff_w = CFG_W_BITS'(MAX_WIDTH);
    end else begin
      eff_w = grid_width_r;
    end
    if (grid_height_r == '0) begin
      eff_h = CFG_H_BITS'(1);
    end else if (grid_height_r > CFG_H_BITS'(MAX_HEIGHT)) begin
      eff_h = CFG_H_BITS'(MAX_HEIGHT);
    end else begin
      eff_h = grid_height_r;
    end
  end

  // position of the next input
  logic [COL_BITS-1:0]    col_r, col_nxt;
  logic [ROW_BITS-1:0]    row_r, row_nxt;
  logic [SAMPLE_BITS-1:0] left_center_r, left_center_nxt;
  logic                   rd_ok_r;
  logic                   in_beat;
  logic [SAMPLE_BITS-1:0] in_sample;

  assign in_sample = in_tdata[SAMPLE_BITS-1:0];

  // row memories and their registered read data
  logic [SAMPLE_BITS-1:0] older_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] newer_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] up_q_r;      // older row, this column
  logic [SAMPLE_BITS-1:0] center_q_r;  // newer row, this column
  logic [SAMPLE_BITS-1:0] right_q_r;   // newer row, next column

  // reads follow the column counter every cycle; a beat writes the same column
  always_ff @(posedge clk) begin
    up_q_r     <= older_mem[col_r];
    center_q_r <= newer_mem[col_r];
    right_q_r  <= newer_mem[col_r + COL_BITS'(1)];
    if (in_beat) begin
      older_mem[col_r] <= center_q_r;
      newer_mem[col_r] <= in_sample;
    end
  end

  // position decode
  logic last_row, last_col, trail_valid, boundary;

  always_comb begin
    last_row    = ({1'b0, row_r} + CFG_H_BITS'(1)) >= eff_h;
    last_col    = ({1'b0, col_r} + CFG_W_BITS'(1)) >= eff_w;
    trail_valid = (row_r != '0);
    // trailing point is on the first row, at or past the last row, or on the first or last column
    boundary    = (row_r == ROW_BITS'(1)) || ({1'b0, row_r} >= eff_h) ||
                  (col_r == '0) || last_col ||
                  (col_r == COL_BITS'(MAX_WIDTH - 1));
  end

  // four-neighbour average, floored
  logic signed [SAMPLE_BITS+1:0] nb_sum;
  logic [SAMPLE_BITS-1:0]        trail_value;

  always_comb begin
    nb_sum = (SAMPLE_BITS+2)'(signed'(up_q_r)) +
             (SAMPLE_BITS+2)'(signed'(in_sample)) +
             (SAMPLE_BITS+2)'(signed'(left_center_r)) +
             (SAMPLE_BITS+2)'(signed'(right_q_r));
    trail_value = boundary ? center_q_r : nb_sum[SAMPLE_BITS+1:2];
  end

  // results of this beat
  result_t    trail_res, own_res, push_first;
  logic [1:0] push_cnt;

  always_comb begin
    trail_res.value  = trail_value;
    trail_res.row    = row_r - ROW_BITS'(1);
    trail_res.column = col_r;
    trail_res.last   = !last_row;
    own_res.value    = in_sample;
    own_res.row      = row_r;
    own_res.column   = col_r;
    own_res.last     = 1'b1;
    push_first       = trail_valid ? trail_res : own_res;
    push_cnt         = 2'd0;
    if (in_beat) begin
      push_cnt = 2'(trail_valid) + 2'(last_row);
    end
  end

  // counters and left neighbour
  always_comb begin
    col_nxt         = col_r;
    row_nxt         = row_r;
    left_center_nxt = left_center_r;
    if (in_beat) begin
      if (trail_valid) begin
        left_center_nxt = center_q_r;
      end
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_BITS'(1);
      end else begin
        col_nxt = col_r + COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= '0;
      row_r         <= '0;
      left_center_r <= '0;
      rd_ok_r       <= 1'b0;
    end else begin
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      left_center_r <= left_center_nxt;
      // read data is stale in the cycle after each beat
      rd_ok_r       <= !in_beat;
    end
  end

  // result queue
  logic [OQ_CNT_BITS-1:0] oq_fill;
  result_t                oq_item;

  jfna_out_fifo u_out_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_cnt    (push_cnt),
    .push_first  (push_first),
    .push_second (own_res),
    .fill        (oq_fill),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_item    (oq_item)
  );

  assign in_tready = rd_ok_r && (oq_fill <= OQ_CNT_BITS'(OQ_DEPTH - 2));
  assign in_beat   = in_tvalid && in_tready;
  assign out_tdata = {(OUT_TDATA_BITS - OUT_FIELD_BITS)'(0),
                      oq_item.column, oq_item.row, oq_item.value};
  assign out_tlast = oq_item.last;

  // checks
  logic out_beat;
  assign out_beat = out_tvalid && out_tready;

  // no beat straight after a beat: the row read must catch up
  `ASSERT_NEXT(a_read_interlock, clk, rst_n, in_beat, !in_tready)
  // the queue never overfills
  `ASSERT_ALWAYS(a_queue_bound, clk, rst_n, oq_fill <= OQ_CNT_BITS'(OQ_DEPTH))
  // a first-row beat of a taller grid leaves the queue to drain only
  `ASSERT_NEXT(a_first_row_silent, clk, rst_n, in_beat && !trail_valid && !last_row,
               oq_fill == $past(oq_fill) - OQ_CNT_BITS'($past(out_beat)))

endmodule
